// ===== rtl/ndot_pkg.sv =====
package ndot_pkg;

	localparam int TS_W          = 64;
	localparam int DISP_W        = 32;
	localparam int IDX_IN_W      = 2;
	localparam int METRIC_W      = TS_W + 1;
	localparam int NUM_SERVERS_D = 4;

	typedef struct packed {
		logic [IDX_IN_W-1:0] server_index;
		logic [TS_W-1:0]     t1_client_send;
		logic [TS_W-1:0]     t4_client_receive;
		logic [TS_W-1:0]     t2_server_receive;
		logic [TS_W-1:0]     t3_server_transmit;
		logic [DISP_W-1:0]   root_dispersion;
	} exch_t;

	typedef struct packed {
		logic signed [TS_W-1:0] round_trip_delay;
		logic signed [TS_W-1:0] clock_offset;
		logic                   new_minimum;
		logic [IDX_IN_W-1:0]    best_server;
		logic                   best_valid;
		logic signed [TS_W-1:0] best_offset;
	} result_t;

endpackage

// ===== rtl/ndot_calc.sv =====
module ndot_calc (
	input  ndot_pkg::exch_t          exch,
	output logic [ndot_pkg::TS_W-1:0] delay,
	output logic [ndot_pkg::TS_W-1:0] offset
);
	import ndot_pkg::*;

	logic [TS_W-1:0] d41;
	logic [TS_W-1:0] d32;
	logic [TS_W-1:0] d21;
	logic [TS_W-1:0] d34;

	assign d41 = exch.t4_client_receive - exch.t1_client_send;
	assign d32 = exch.t3_server_transmit - exch.t2_server_receive;
	assign d21 = exch.t2_server_receive - exch.t1_client_send;
	assign d34 = exch.t3_server_transmit - exch.t4_client_receive;

	assign delay = d41 - d32;

	// floor of the exact 65-bit sum over two
	assign offset = {d21[TS_W-1], d21[TS_W-1:1]} + {d34[TS_W-1], d34[TS_W-1:1]}
		+ {{(TS_W-1){1'b0}}, d21[0] & d34[0]};

endmodule

// ===== rtl/ndot_store.sv =====
module ndot_store #(
	parameter int NUM_SERVERS = ndot_pkg::NUM_SERVERS_D
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             update,
	input  logic [ndot_pkg::IDX_IN_W-1:0]    server_index,
	input  logic [ndot_pkg::TS_W-1:0]        delay,
	input  logic [ndot_pkg::TS_W-1:0]        offset,
	input  logic [ndot_pkg::DISP_W-1:0]      root_dispersion,
	output logic                             new_minimum,
	output logic                             entry_valid [NUM_SERVERS],
	output logic [ndot_pkg::METRIC_W-1:0]    entry_metric [NUM_SERVERS],
	output logic [ndot_pkg::TS_W-1:0]        entry_offset [NUM_SERVERS]
);
	import ndot_pkg::*;

	logic [TS_W-1:0]   max_q  [NUM_SERVERS];
	logic [TS_W-1:0]   min_q  [NUM_SERVERS];
	logic [TS_W-1:0]   off_q  [NUM_SERVERS];
	logic [DISP_W-1:0] disp_q [NUM_SERVERS];
	logic              valid_q [NUM_SERVERS];

	logic              cur_valid;
	logic [TS_W-1:0]   cur_max;
	logic [TS_W-1:0]   cur_min;
	logic              in_range;
	logic              take_max;
	logic              take_min;

	assign in_range = 32'(server_index) < NUM_SERVERS;

	always_comb begin
		cur_valid = 1'b0;
		cur_max   = '0;
		cur_min   = '0;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			if (32'(server_index) == i) begin
				cur_valid = valid_q[i];
				cur_max   = max_q[i];
				cur_min   = min_q[i];
			end
		end
	end

	assign take_max    = !cur_valid || ($signed(cur_max) < $signed(delay));
	assign take_min    = !cur_valid || ($signed(delay) < $signed(cur_min));
	assign new_minimum = in_range && take_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (update && in_range) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				if (32'(server_index) == i) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update && in_range) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				if (32'(server_index) == i) begin
					disp_q[i] <= root_dispersion;
					if (take_max) begin
						max_q[i] <= delay;
					end
					if (take_min) begin
						min_q[i] <= delay;
						off_q[i] <= offset;
					end
				end
			end
		end
	end

	// spread plus dispersion in 32.32, kept with its carry
	always_comb begin
		for (int i = 0; i < NUM_SERVERS; i++) begin
			entry_valid[i]  = valid_q[i];
			entry_offset[i] = off_q[i];
			entry_metric[i] = {1'b0, max_q[i] - min_q[i]}
				+ {{(METRIC_W-DISP_W-16){1'b0}}, disp_q[i], 16'b0};
		end
	end

endmodule

// ===== rtl/ndot_select.sv =====
module ndot_select #(
	parameter int NUM_SERVERS = ndot_pkg::NUM_SERVERS_D
) (
	input  logic                          entry_valid [NUM_SERVERS],
	input  logic [ndot_pkg::METRIC_W-1:0] entry_metric [NUM_SERVERS],
	input  logic [ndot_pkg::TS_W-1:0]     entry_offset [NUM_SERVERS],
	output logic [ndot_pkg::IDX_IN_W-1:0] best_server,
	output logic                          best_valid,
	output logic [ndot_pkg::TS_W-1:0]     best_offset
);
	import ndot_pkg::*;

	localparam int IDX_W  = $clog2(NUM_SERVERS);
	localparam int LEAVES = 2 ** IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic                nv [NODES];
	logic [METRIC_W-1:0] nm [NODES];
	logic [IDX_W-1:0]    ni [NODES];
	logic [TS_W-1:0]     no [NODES];

	// binary tree, left child holds the lower indices so ties go left
	always_comb begin
		for (int j = 0; j < LEAVES; j++) begin
			if (j < NUM_SERVERS) begin
				nv[LEAVES-1+j] = entry_valid[j];
				nm[LEAVES-1+j] = entry_metric[j];
				no[LEAVES-1+j] = entry_offset[j];
			end else begin
				nv[LEAVES-1+j] = 1'b0;
				nm[LEAVES-1+j] = '0;
				no[LEAVES-1+j] = '0;
			end
			ni[LEAVES-1+j] = IDX_W'(j);
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (nv[2*k+1] && (!nv[2*k+2] || nm[2*k+1] <= nm[2*k+2])) begin
				nv[k] = nv[2*k+1];
				nm[k] = nm[2*k+1];
				ni[k] = ni[2*k+1];
				no[k] = no[2*k+1];
			end else begin
				nv[k] = nv[2*k+2];
				nm[k] = nm[2*k+2];
				ni[k] = ni[2*k+2];
				no[k] = no[2*k+2];
			end
		end
	end

	assign best_valid  = nv[0];
	assign best_server = nv[0] ? IDX_IN_W'(ni[0]) : '0;
	assign best_offset = nv[0] ? no[0] : '0;

endmodule

// ===== rtl/ntp_delay_offset_tracker.sv =====
// NTP delay and offset tracker.
// exch channel: one transaction per time-server exchange (server index, four
// 32.32 timestamps, 16.16 root dispersion). result channel: one transaction
// per exchange, in order, with round-trip delay, clock offset, the new-minimum
// flag and the best server with its stored offset.
// Throughput: one exchange per cycle while result_ready is high. There are five
// register stages (input, delay and offset, per-server store update, dispersion
// metrics, best-server result).
// Stalls: a stage holds only while the stage after it is full and held, so
// bubbles collapse and exch_ready drops only once every stage is occupied
// and result_ready is low. Nothing is lost or repeated under a stall.
// Reset: arst_n clears all stage valids and the per-server sample flags;
// no server counts until it has seen an exchange, and the block is ready
// in the first cycle after reset.
module ntp_delay_offset_tracker #(
	parameter int NUM_SERVERS = ndot_pkg::NUM_SERVERS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              exch_valid,
	output logic              exch_ready,
	input  ndot_pkg::exch_t   exch,
	output logic              result_valid,
	input  logic              result_ready,
	output ndot_pkg::result_t result
);
	import ndot_pkg::*;

	// stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_q;
	logic en1, en2, en3, en4, en5;

	// stage payloads
	exch_t               exch_s1;
	logic [IDX_IN_W-1:0] srv_s2;
	logic [TS_W-1:0]     delay_s2, offset_s2;
	logic [DISP_W-1:0]   disp_s2;
	logic [TS_W-1:0]     delay_s3, offset_s3;
	logic                newmin_s3;
	logic [TS_W-1:0]     delay_s4, offset_s4;
	logic                newmin_s4;
	logic                mvalid_s4 [NUM_SERVERS];
	logic [METRIC_W-1:0] metric_s4 [NUM_SERVERS];
	logic [TS_W-1:0]     moff_s4   [NUM_SERVERS];
	result_t             result_q;

	logic [TS_W-1:0]     delay_c, offset_c;
	logic                newmin_c;
	logic                ev_c [NUM_SERVERS];
	logic [METRIC_W-1:0] em_c [NUM_SERVERS];
	logic [TS_W-1:0]     eo_c [NUM_SERVERS];
	logic [IDX_IN_W-1:0] best_server_c;
	logic                best_valid_c;
	logic [TS_W-1:0]     best_offset_c;

	// a stage may load when it is empty or its content moves on
	assign en5 = !valid_q || result_ready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign exch_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en1) valid_s1 <= exch_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_q  <= valid_s4;
		end
	end

	// stage 1 -> 2: delay and offset of the exchange
	ndot_calc u_calc (
		.exch   (exch_s1),
		.delay  (delay_c),
		.offset (offset_c)
	);

	// stage 2 -> 3: update the server entry as the transaction enters stage 3;
	// stage 3 -> 4: metrics read while it leaves, so they include its update
	ndot_store #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_store (
		.clk             (clk),
		.arst_n          (arst_n),
		.update          (valid_s2 && en3),
		.server_index    (srv_s2),
		.delay           (delay_s2),
		.offset          (offset_s2),
		.root_dispersion (disp_s2),
		.new_minimum     (newmin_c),
		.entry_valid     (ev_c),
		.entry_metric    (em_c),
		.entry_offset    (eo_c)
	);

	// stage 4 -> result: pick the least metric
	ndot_select #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_select (
		.entry_valid  (mvalid_s4),
		.entry_metric (metric_s4),
		.entry_offset (moff_s4),
		.best_server  (best_server_c),
		.best_valid   (best_valid_c),
		.best_offset  (best_offset_c)
	);

	always_ff @(posedge clk) begin
		if (en1 && exch_valid) begin
			exch_s1 <= exch;
		end
		if (en2 && valid_s1) begin
			srv_s2    <= exch_s1.server_index;
			disp_s2   <= exch_s1.root_dispersion;
			delay_s2  <= delay_c;
			offset_s2 <= offset_c;
		end
		if (en3 && valid_s2) begin
			delay_s3  <= delay_s2;
			offset_s3 <= offset_s2;
			newmin_s3 <= newmin_c;
		end
		if (en4 && valid_s3) begin
			delay_s4  <= delay_s3;
			offset_s4 <= offset_s3;
			newmin_s4 <= newmin_s3;
			for (int i = 0; i < NUM_SERVERS; i++) begin
				mvalid_s4[i] <= ev_c[i];
				metric_s4[i] <= em_c[i];
				moff_s4[i]   <= eo_c[i];
			end
		end
		if (en5 && valid_s4) begin
			result_q.round_trip_delay <= delay_s4;
			result_q.clock_offset     <= offset_s4;
			result_q.new_minimum      <= newmin_s4;
			result_q.best_server      <= best_server_c;
			result_q.best_valid       <= best_valid_c;
			result_q.best_offset      <= best_offset_c;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	import ndot_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int PHASE_ITEMS   = 600;
	localparam int HOLD_CYCLES   = 40;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int NUM_DIRECTED  = 15;

	// One row of the directed table: the exchange, and optionally a result
	// that is obvious from the arithmetic and is checked as typed.
	typedef struct {
		exch_t   x;
		bit      typed;
		result_t r;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    exch_valid;
	logic    exch_ready;
	exch_t   exch;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// Shadow of the per-server tracking state.
	logic signed [TS_W-1:0] max_delay_q [NUM_SERVERS_D];
	logic signed [TS_W-1:0] min_delay_q [NUM_SERVERS_D];
	logic signed [TS_W-1:0] min_offset_q [NUM_SERVERS_D];
	logic [DISP_W-1:0]      root_disp_q [NUM_SERVERS_D];
	logic                   server_seen_q [NUM_SERVERS_D];

	result_t   pending_results[$];
	stim_row_t dir_rows [NUM_DIRECTED];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_off_req;
	bit          cur_typed;
	result_t     cur_typed_res;
	int unsigned mismatches;
	int unsigned cycle_count;

	ntp_delay_offset_tracker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.exch_valid   (exch_valid),
		.exch_ready   (exch_ready),
		.exch         (exch),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #CLK_HALF clk = ~clk;

	// Track one accepted exchange: update the shadow state and return the
	// result the block must report for it.
	function automatic result_t track_exchange(input exch_t x);
		result_t                 r;
		logic signed [TS_W-1:0]  delay;
		logic signed [TS_W-1:0]  d21;
		logic signed [TS_W-1:0]  d34;
		logic signed [TS_W:0]    ofs_sum;
		logic [TS_W-1:0]         spread;
		logic [METRIC_W-1:0]     metric;
		logic [METRIC_W-1:0]     best_metric;
		int                      s;

		delay   = (x.t4_client_receive - x.t1_client_send)
			- (x.t3_server_transmit - x.t2_server_receive);
		d21     = x.t2_server_receive - x.t1_client_send;
		d34     = x.t3_server_transmit - x.t4_client_receive;
		// Exact 65-bit sum, then arithmetic shift gives the floor of the mean.
		ofs_sum = $signed({d21[TS_W-1], d21}) + $signed({d34[TS_W-1], d34});

		r                  = '0;
		r.round_trip_delay = delay;
		r.clock_offset     = ofs_sum[TS_W:1];

		s = int'(x.server_index);
		if (!server_seen_q[s]) begin
			// First sample of a server seeds both extremes and the offset.
			server_seen_q[s] = 1'b1;
			max_delay_q[s]   = delay;
			min_delay_q[s]   = delay;
			min_offset_q[s]  = r.clock_offset;
			r.new_minimum    = 1'b1;
		end else begin
			if (delay > max_delay_q[s])
				max_delay_q[s] = delay;
			if (delay < min_delay_q[s]) begin
				min_delay_q[s]  = delay;
				min_offset_q[s] = r.clock_offset;
				r.new_minimum   = 1'b1;
			end
		end
		root_disp_q[s] = x.root_dispersion;

		// Pick the server with the least spread plus dispersion; strict
		// compare keeps the lowest index on ties.
		best_metric = '0;
		for (int i = 0; i < NUM_SERVERS_D; i++) begin
			if (server_seen_q[i]) begin
				spread = max_delay_q[i] - min_delay_q[i];
				metric = {1'b0, spread} + {17'b0, root_disp_q[i], 16'b0};
				if (!r.best_valid || metric < best_metric) begin
					r.best_valid  = 1'b1;
					best_metric   = metric;
					r.best_server = IDX_IN_W'(i);
					r.best_offset = min_offset_q[i];
				end
			end
		end
		return r;
	endfunction

	function automatic stim_row_t mk_row(input int idx, input logic [63:0] t1,
			input logic [63:0] t2, input logic [63:0] t3, input logic [63:0] t4,
			input logic [31:0] disp, input bit typed, input result_t r);
		stim_row_t row;

		row.x.server_index       = IDX_IN_W'(idx);
		row.x.t1_client_send     = t1;
		row.x.t2_server_receive  = t2;
		row.x.t3_server_transmit = t3;
		row.x.t4_client_receive  = t4;
		row.x.root_dispersion    = disp;
		row.typed                = typed;
		row.r                    = r;
		return row;
	endfunction

	// Mostly plausible exchanges (short paths, small skew, modest dispersion)
	// so min/max tracking and best-server swaps happen often; the rest is raw
	// noise that hits every bit and wild delays.
	function automatic exch_t rand_exchange();
		exch_t       x;
		logic [63:0] path_out;
		logic [63:0] path_back;
		logic [63:0] turn;
		logic [63:0] skew;
		int unsigned pick;

		pick           = $urandom_range(99);
		x.server_index = IDX_IN_W'($urandom_range(NUM_SERVERS_D - 1));
		if (pick < 75) begin
			path_out  = 64'($urandom_range(1 << 24));
			path_back = 64'($urandom_range(1 << 24));
			turn      = 64'($urandom_range(1 << 20));
			skew      = {36'b0, 28'($urandom)} - 64'(1 << 27);
			x.t1_client_send     = {$urandom, $urandom};
			x.t2_server_receive  = x.t1_client_send + path_out + skew;
			x.t3_server_transmit = x.t2_server_receive + turn;
			x.t4_client_receive  = x.t3_server_transmit + path_back - skew;
			x.root_dispersion    = ($urandom_range(9) == 0) ? $urandom
				: 32'($urandom_range(16'h4000));
		end else begin
			x.t1_client_send     = {$urandom, $urandom};
			x.t2_server_receive  = {$urandom, $urandom};
			x.t3_server_transmit = {$urandom, $urandom};
			x.t4_client_receive  = {$urandom, $urandom};
			x.root_dispersion    = $urandom;
		end
		return x;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Offer one exchange: idle at random first, then hold valid and payload
	// until the block takes it. Enter and leave at a falling edge.
	task automatic send_exchange(input exch_t x, input bit typed, input result_t r);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			exch_valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed     = typed;
		cur_typed_res = r;
		exch_valid   <= 1'b1;
		exch         <= x;
		@(posedge clk);
		while (!exch_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Directed table. Typed rows carry results that follow at a glance from
	// the arithmetic; the rest go through the predictor.
	initial begin
		// first sample after reset, all-zero stamps
		dir_rows[0]  = mk_row(0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 1'b1,
			'{64'sh0, 64'sh0, 1'b1, 2'd0, 1'b1, 64'sh0});
		// full root dispersion keeps server 1 out of the lead
		dir_rows[1]  = mk_row(1, 64'h0, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 1'b1,
			'{64'sh0, 64'sh0, 1'b1, 2'd0, 1'b1, 64'sh0});
		// client send of all ones wraps to a delay of one
		dir_rows[2]  = mk_row(2, '1, 64'h0, 64'h0, 64'h0, 32'h0, 1'b1,
			'{64'sh1, 64'sh0, 1'b1, 2'd0, 1'b1, 64'sh0});
		// both differences minus one: offset floors to minus one
		dir_rows[3]  = mk_row(3, 64'h0, '1, '1, 64'h0, 32'h0, 1'b1,
			'{64'sh0, -64'sh1, 1'b1, 2'd0, 1'b1, 64'sh0});
		// largest positive delay widens server 0; lowest index among zeros wins
		dir_rows[4]  = mk_row(0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 32'h0, 1'b1,
			'{64'sh7FFF_FFFF_FFFF_FFFF, 64'sh3FFF_FFFF_FFFF_FFFF, 1'b0, 2'd2, 1'b1,
			64'sh0});
		// drive server 1 to both extremes, then a full dispersion on top
		dir_rows[5]  = mk_row(1, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 32'h1,
			1'b0, NO_RESULT);
		dir_rows[6]  = mk_row(1, 64'h0, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 32'h2,
			1'b0, NO_RESULT);
		dir_rows[7]  = mk_row(1, 64'h5, 64'h5, 64'h5, 64'h5, 32'hFFFF_FFFF, 1'b0,
			NO_RESULT);
		dir_rows[8]  = mk_row(2, '1, '1, '1, '1, 32'hFFFF_FFFF, 1'b0, NO_RESULT);
		// odd offset sums round toward minus infinity
		dir_rows[9]  = mk_row(3, 64'h0, 64'h1, 64'h0, 64'h0, 32'h10, 1'b0, NO_RESULT);
		dir_rows[10] = mk_row(3, 64'h1, 64'h0, 64'h0, 64'h0, 32'h0, 1'b0, NO_RESULT);
		dir_rows[11] = mk_row(2, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'hAAAA_5555, 1'b0,
			NO_RESULT);
		// delay equal to the current minimum is not a new minimum
		dir_rows[12] = mk_row(2, 64'h9, 64'h9, 64'h9, 64'h9, 32'h5555_AAAA, 1'b0,
			NO_RESULT);
		// small negative delay takes the minimum of server 0
		dir_rows[13] = mk_row(0, 64'h0, 64'h0, 64'h1, 64'h0, 32'h3, 1'b0, NO_RESULT);
		dir_rows[14] = mk_row(3, 64'h1_0000_0000, 64'h1_0000_1000, 64'h1_0000_2000,
			64'h1_0000_0800, 32'h0, 1'b0, NO_RESULT);
	end

	// Accept monitor: predict on every exchange transaction, check every
	// result transaction against the oldest prediction.
	always @(posedge clk) begin : monitor
		result_t want;

		if (arst_n && exch_valid && exch_ready) begin
			want = track_exchange(exch);
			if (cur_typed)
				want = cur_typed_res;
			pending_results.push_back(want);
		end
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending, actual %h", $time, result);
			end else begin
				want = pending_results.pop_front();
				check_field("round_trip_delay", want.round_trip_delay,
					result.round_trip_delay);
				check_field("clock_offset", want.clock_offset, result.clock_offset);
				check_field("new_minimum", 64'(want.new_minimum), 64'(result.new_minimum));
				check_field("best_server", 64'(want.best_server), 64'(result.best_server));
				check_field("best_valid", 64'(want.best_valid), 64'(result.best_valid));
				check_field("best_offset", want.best_offset, result.best_offset);
			end
		end
	end

	// Receiver: stall at random per the current idle rate; on request, hold
	// off for a long stretch so the pipeline fills and drops exch_ready.
	always begin
		@(negedge clk);
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			result_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		exch_valid    = 1'b0;
		exch          = '0;
		result_ready  = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 66;
		hold_off_req  = 1'b0;
		cur_typed     = 1'b0;
		cur_typed_res = NO_RESULT;
		mismatches    = 0;
		cycle_count   = 0;
		for (int i = 0; i < NUM_SERVERS_D; i++) begin
			max_delay_q[i]   = '0;
			min_delay_q[i]   = '0;
			min_offset_q[i]  = '0;
			root_disp_q[i]   = '0;
			server_seen_q[i] = 1'b0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table under the first idle mix.
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_exchange(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].r);

		// Random traffic: busy sender with lazy receiver, then swapped.
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_exchange(rand_exchange(), 1'b0, NO_RESULT);
		send_idle_pct = 66;
		recv_idle_pct = 33;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_exchange(rand_exchange(), 1'b0, NO_RESULT);

		// Full rate both sides, with one long receiver hold-off up front.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req  = 1'b1;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_exchange(rand_exchange(), 1'b0, NO_RESULT);
		exch_valid <= 1'b0;

		// Drain, then give the pipeline time to show any stray result.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
